@@ hw/rtl/cfls_pkg.sv @@
// Shared types and codes for the latency-stamping circular FIFO.
package cfls_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;  // new request taken: latch timestamp and status, clear result
    logic    wr_en;    // store word and stamp at tail
    logic    rd_en;    // fetch head entry from the stores
    logic    lat_en;   // subtract and saturate latency
    logic    sqr_en;   // square latency, bump count and sum
    logic    acc_en;   // add square, retire head entry
    status_e status;
  } cmd_t;

  // Queue status back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

  localparam int unsigned LatW  = 32;
  localparam int unsigned WordW = 64;

endpackage

@@ hw/rtl/cfls_ctrl.sv @@
// Sequencer for one request: accept, fetch, latency, square, accumulate, deliver.
module cfls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          operation_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  cfls_pkg::sts_t sts_i,
  output cfls_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAT,
    S_SQR,
    S_ACC,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   is_read;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign is_read     = (operation_i == cfls_pkg::OP_READ);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = cfls_pkg::STATUS_OK;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.capture = 1'b1;
          if (is_read) begin
            if (sts_i.empty) begin
              cmd_o.status = cfls_pkg::STATUS_EMPTY;
              state_d      = S_OUT;
              out_valid_d  = 1'b1;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_LAT;
            end
          end else begin
            if (sts_i.full) begin
              cmd_o.status = cfls_pkg::STATUS_FULL;
            end else begin
              cmd_o.wr_en = 1'b1;
            end
            state_d     = S_OUT;
            out_valid_d = 1'b1;
          end
        end
      end
      S_LAT: begin
        cmd_o.lat_en = 1'b1;
        state_d      = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_OUT;
        out_valid_d  = 1'b1;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_OUT))
    else $error("result valid outside delivery state");

  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_read && !sts_i.empty) |=> (state_q == S_LAT))
    else $error("good read did not start the latency sequence");

  a_read_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAT) |=> (state_q == S_SQR) ##1 (state_q == S_ACC) ##1 out_valid_q)
    else $error("read sequence broken");

endmodule

@@ hw/rtl/cfls_dp.sv @@
// Queue stores, pointers, latency arithmetic and statistics accumulators.
module cfls_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfls_pkg::cmd_t                cmd_i,
  output cfls_pkg::sts_t                sts_o,
  input  logic [cfls_pkg::WordW-1:0]    write_data_i,
  input  logic [cfls_pkg::WordW-1:0]    now_i,
  output logic [cfls_pkg::WordW-1:0]    read_data_o,
  output logic [1:0]                    status_o,
  output logic [cfls_pkg::LatW-1:0]     latency_o,
  output logic [cfls_pkg::LatW-1:0]     read_count_o,
  output logic [cfls_pkg::WordW-1:0]    latency_total_o,
  output logic [cfls_pkg::WordW-1:0]    latency_square_total_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  logic [cfls_pkg::WordW-1:0] data_mem  [DEPTH];
  logic [cfls_pkg::WordW-1:0] stamp_mem [DEPTH];

  logic [PtrW-1:0]            head_q, tail_q, head_nxt, tail_nxt;
  logic                       empty_q;
  logic [cfls_pkg::WordW-1:0] now_q;
  logic [cfls_pkg::WordW-1:0] data_rd_q, stamp_rd_q;
  logic [cfls_pkg::WordW-1:0] read_data_q;
  cfls_pkg::status_e          status_q;
  logic [cfls_pkg::LatW-1:0]  latency_q;
  logic [cfls_pkg::WordW-1:0] sq_q;
  logic [cfls_pkg::LatW-1:0]  count_q;
  logic [cfls_pkg::WordW-1:0] sum_q, sqsum_q;
  logic [cfls_pkg::WordW-1:0] diff;
  logic [cfls_pkg::LatW-1:0]  lat_sat;
  logic [cfls_pkg::WordW-1:0] sq_w;

  // Wrap at DEPTH, which need not be a power of two.
  assign head_nxt = (head_q == LastIdx) ? '0 : head_q + PtrW'(1);
  assign tail_nxt = (tail_q == LastIdx) ? '0 : tail_q + PtrW'(1);

  assign sts_o.empty = empty_q;
  assign sts_o.full  = !empty_q && (head_q == tail_q);

  assign diff    = now_q - stamp_rd_q;
  assign lat_sat = (diff[cfls_pkg::WordW-1:cfls_pkg::LatW] != '0) ? '1
                                                                   : diff[cfls_pkg::LatW-1:0];
  assign sq_w    = {32'd0, latency_q} * {32'd0, latency_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      data_mem[tail_q]  <= write_data_i;
      stamp_mem[tail_q] <= now_i;
    end
    if (cmd_i.rd_en) begin
      data_rd_q  <= data_mem[head_q];
      stamp_rd_q <= stamp_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q       <= now_i;
      status_q    <= cmd_i.status;
      read_data_q <= '0;
      latency_q   <= '0;
    end
    if (cmd_i.lat_en) begin
      latency_q   <= lat_sat;
      read_data_q <= data_rd_q;
    end
    if (cmd_i.sqr_en) begin
      sq_q <= sq_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        tail_q  <= tail_nxt;
        empty_q <= 1'b0;
      end
      if (cmd_i.sqr_en) begin
        count_q <= count_q + 32'd1;
        sum_q   <= sum_q + {32'd0, latency_q};
      end
      if (cmd_i.acc_en) begin
        sqsum_q <= sqsum_q + sq_q;
        head_q  <= head_nxt;
        if (head_nxt == tail_q) begin
          empty_q <= 1'b1;
        end
      end
    end
  end

  assign read_data_o            = read_data_q;
  assign status_o               = status_q;
  assign latency_o              = latency_q;
  assign read_count_o           = count_q;
  assign latency_total_o        = sum_q;
  assign latency_square_total_o = sqsum_q;

  a_write_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |=> !empty_q)
    else $error("queue empty after a write");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqr_en |=> (count_q == $past(count_q) + 32'd1))
    else $error("read count did not advance");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !(!empty_q && (head_q == tail_q)))
    else $error("write into full queue");

endmodule

@@ hw/rtl/circular_fifo_latency_stats.sv @@
// Top level: circular FIFO with timestamped entries and read-latency statistics.
//
//  channel  valid       stall         payload
//  input    in_valid_i  in_stall_o    operation_i, write_data_i, now_i
//  output   out_valid_o out_stall_i   read_data_o, status_o, latency_o, read_count_o,
//                                     latency_total_o, latency_square_total_o
//
// One request at a time. A write, a dropped write or a read of an empty queue shows
// its result the cycle after acceptance; a successful read passes through store fetch,
// latency subtract, 32x32 square and square accumulate before its result shows.
// The next request is taken the cycle after the result leaves.
// Reset leaves the queue empty and the statistics at zero; stores need no clearing.
// A stalled result holds, and input stays stalled until it is taken.
module circular_fifo_latency_stats #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] write_data_i,
  input  logic [63:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_data_o,
  output logic [1:0]  status_o,
  output logic [31:0] latency_o,
  output logic [31:0] read_count_o,
  output logic [63:0] latency_total_o,
  output logic [63:0] latency_square_total_o
);

  cfls_pkg::cmd_t cmd;
  cfls_pkg::sts_t sts;

  cfls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .write_data_i           (write_data_i),
    .now_i                  (now_i),
    .read_data_o            (read_data_o),
    .status_o               (status_o),
    .latency_o              (latency_o),
    .read_count_o           (read_count_o),
    .latency_total_o        (latency_total_o),
    .latency_square_total_o (latency_square_total_o)
  );

endmodule
